@@ hw/rtl/kch_pkg.sv @@
// Shared types and constants of the key count hash table.
package kch_pkg;

  // Multiplier of the key hash; only its low table-index bits matter.
  localparam logic [63:0] HASH_MULT = 64'd1099511628211;

  // Width of the slot field of a response.
  localparam int unsigned SLOT_W = 10;

  // One table entry; a zero count marks an empty slot.
  typedef struct packed {
    logic [31:0] dev;
    logic [63:0] ino;
    logic [63:0] count;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_CHECK
  } state_e;

endpackage

@@ hw/rtl/kch_hash.sv @@
// Start slot of a probe sequence, taken from the low bits of the key hash.
module kch_hash #(
  parameter int unsigned TABLE_LOG2 = 10
) (
  input  logic [TABLE_LOG2-1:0] ino_lo_i,
  input  logic [TABLE_LOG2-1:0] dev_lo_i,
  output logic [TABLE_LOG2-1:0] idx_o
);

  localparam logic [TABLE_LOG2-1:0] MultLo = kch_pkg::HASH_MULT[TABLE_LOG2-1:0];

  logic [2*TABLE_LOG2-1:0] prod;

  // The low bits of a 64-bit product depend only on the low bits of its operands.
  assign prod  = {{TABLE_LOG2{1'b0}}, ino_lo_i} * {{TABLE_LOG2{1'b0}}, MultLo};
  assign idx_o = prod[TABLE_LOG2-1:0] ^ dev_lo_i;

endmodule

@@ hw/rtl/kch_ram.sv @@
// Single-port-read, single-port-write table memory with registered read data.
module kch_ram #(
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 160
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/key_count_hash_table.sv @@
// Top level of the key count hash table: probe sequencer, table memory and response register.
//
//   Channel  Fields                                                        Handshake
//   in       kind, dev, ino, slot_index                                    in_valid_i, in_ready_o
//   out      slot, entry_dev, entry_ino, entry_count, newly_claimed, dropped out_valid_o, out_ready_i
//
// A request is taken in ST_IDLE; ST_HASH then reads its start slot and ST_CHECK probes P slots
// (P = 1 for a slot read, at most 2**TABLE_LOG2 for a tally) before the next request is taken;
// the single read port of the table memory visits one slot per cycle.
// After reset the table is cleared one slot per cycle, all 2**TABLE_LOG2 slots; no request is
// taken during that pass.
// A waiting response stalls only the request that has to replace it; a new request is taken
// while the previous response is still held.
module key_count_hash_table #(
  parameter int unsigned TABLE_LOG2 = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_kind_i,
  input  logic [31:0] in_dev_i,
  input  logic [63:0] in_ino_i,
  input  logic [9:0]  in_slot_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  out_slot_o,
  output logic [31:0] out_entry_dev_o,
  output logic [63:0] out_entry_ino_o,
  output logic [63:0] out_entry_count_o,
  output logic        out_newly_claimed_o,
  output logic        out_dropped_o
);

  localparam int unsigned EntryW = $bits(kch_pkg::entry_t);
  localparam int unsigned SlotW  = kch_pkg::SLOT_W;

  kch_pkg::state_e state_q, state_d;

  logic [TABLE_LOG2-1:0] clr_q, clr_d;
  logic [TABLE_LOG2-1:0] addr_q, addr_d;
  logic [TABLE_LOG2-1:0] probe_q, probe_d;
  logic                  kind_q;
  logic [31:0]           dev_q;
  logic [63:0]           ino_q;
  logic [9:0]            sidx_q;

  logic                  out_valid_q;
  logic [9:0]            out_slot_q;
  logic [31:0]           out_dev_q;
  logic [63:0]           out_ino_q;
  logic [63:0]           out_count_q;
  logic                  out_claimed_q;
  logic                  out_dropped_q;

  logic                  accept;
  logic                  emit;
  logic                  out_free;
  logic [TABLE_LOG2-1:0] hash_idx;
  logic [TABLE_LOG2-1:0] start_idx;

  logic                  ram_we;
  logic [TABLE_LOG2-1:0] ram_waddr;
  kch_pkg::entry_t       ram_wdata;
  logic                  ram_re;
  logic [TABLE_LOG2-1:0] ram_raddr;
  logic [EntryW-1:0]     ram_rdata;
  kch_pkg::entry_t       rd_entry;

  logic                  rd_empty;
  logic                  key_match;
  logic [63:0]           count_inc;

  logic [9:0]            res_slot;
  logic [31:0]           res_dev;
  logic [63:0]           res_ino;
  logic [63:0]           res_count;
  logic                  res_claimed;
  logic                  res_dropped;

  kch_hash #(
    .TABLE_LOG2(TABLE_LOG2)
  ) u_hash (
    .ino_lo_i(ino_q[TABLE_LOG2-1:0]),
    .dev_lo_i(dev_q[TABLE_LOG2-1:0]),
    .idx_o   (hash_idx)
  );

  kch_ram #(
    .ADDR_W(TABLE_LOG2),
    .DATA_W(EntryW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry  = ram_rdata;
  assign rd_empty  = (rd_entry.count == 64'd0);
  assign key_match = (rd_entry.dev == dev_q) && (rd_entry.ino == ino_q);
  // Counts saturate at the all-ones value.
  assign count_inc = (&rd_entry.count) ? rd_entry.count : rd_entry.count + 64'd1;
  assign start_idx = kind_q ? TABLE_LOG2'(sidx_q) : hash_idx;
  assign out_free  = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kch_pkg::ST_CLEAR: begin
        if (&clr_q) begin
          state_d = kch_pkg::ST_IDLE;
        end
      end
      kch_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = kch_pkg::ST_HASH;
        end
      end
      kch_pkg::ST_HASH: begin
        state_d = kch_pkg::ST_CHECK;
      end
      kch_pkg::ST_CHECK: begin
        if (emit) begin
          state_d = kch_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kch_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = addr_q;
    emit        = 1'b0;
    clr_d       = clr_q;
    res_slot    = SlotW'(addr_q);
    res_count   = rd_entry.count;
    res_dev     = rd_empty ? 32'd0 : rd_entry.dev;
    res_ino     = rd_empty ? 64'd0 : rd_entry.ino;
    res_claimed = 1'b0;
    res_dropped = 1'b0;
    unique case (state_q)
      kch_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
      end
      kch_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      kch_pkg::ST_HASH: begin
        ram_re    = 1'b1;
        ram_raddr = start_idx;
      end
      kch_pkg::ST_CHECK: begin
        if (kind_q) begin
          emit = out_free;
        end else if (rd_empty) begin
          emit            = out_free;
          ram_we          = out_free;
          ram_wdata.dev   = dev_q;
          ram_wdata.ino   = ino_q;
          ram_wdata.count = 64'd1;
          res_dev         = dev_q;
          res_ino         = ino_q;
          res_count       = 64'd1;
          res_claimed     = 1'b1;
        end else if (key_match) begin
          emit            = out_free;
          ram_we          = out_free;
          ram_wdata.dev   = dev_q;
          ram_wdata.ino   = ino_q;
          ram_wdata.count = count_inc;
          res_count       = count_inc;
        end else if (&probe_q) begin
          // Every slot holds another key: the tally is discarded.
          emit        = out_free;
          res_slot    = '0;
          res_dev     = 32'd0;
          res_ino     = 64'd0;
          res_count   = 64'd0;
          res_dropped = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = addr_q + 1'b1;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    addr_d  = ram_re ? ram_raddr : addr_q;
    probe_d = probe_q;
    if (state_q == kch_pkg::ST_HASH) begin
      probe_d = '0;
    end else if (ram_re) begin
      probe_d = probe_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kch_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    probe_q <= probe_d;
    if (accept) begin
      kind_q <= in_kind_i;
      dev_q  <= in_dev_i;
      ino_q  <= in_ino_i;
      sidx_q <= in_slot_index_i;
    end
    if (emit) begin
      out_slot_q    <= res_slot;
      out_dev_q     <= res_dev;
      out_ino_q     <= res_ino;
      out_count_q   <= res_count;
      out_claimed_q <= res_claimed;
      out_dropped_q <= res_dropped;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_slot_o          = out_slot_q;
  assign out_entry_dev_o     = out_dev_q;
  assign out_entry_ino_o     = out_ino_q;
  assign out_entry_count_o   = out_count_q;
  assign out_newly_claimed_o = out_claimed_q;
  assign out_dropped_o       = out_dropped_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && out_valid_q |-> out_ready_i)
    else $error("response register loaded while a response is still held");

  a_rw_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("table written and read in the same cycle");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second request taken while one is in progress");

  a_claim_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_newly_claimed_o |-> out_entry_count_o == 64'd1 && !out_dropped_o)
    else $error("claimed slot does not hold a count of one");

  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_dropped_o |-> out_entry_count_o == 64'd0 && out_slot_o == '0)
    else $error("dropped tally reports a slot");

endmodule

@@ test/count_table_checker.sv @@
// Response checker of the key count hash table, with the request kinds it shares with the stimulus.
package kch_tb_pkg;

  typedef enum logic {
    KIND_TALLY = 1'b0,
    KIND_READ  = 1'b1
  } req_kind_e;

endpackage

module count_table_checker #(
  parameter int unsigned TABLE_LOG2 = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic                       in_kind_i,
  input  logic [31:0]                in_dev_i,
  input  logic [63:0]                in_ino_i,
  input  logic [9:0]                 in_slot_index_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [9:0]                 out_slot_i,
  input  logic [31:0]                out_entry_dev_i,
  input  logic [63:0]                out_entry_ino_i,
  input  logic [63:0]                out_entry_count_i,
  input  logic                       out_newly_claimed_i,
  input  logic                       out_dropped_i,
  output int                         mismatch_count_o,
  output int                         pending_count_o,
  output int                         drop_count_o,
  output logic [2**TABLE_LOG2-1:0]   filled_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_SIZE = 2 ** TABLE_LOG2;
  localparam logic [63:0] HASH_PRIME = 64'd1099511628211;

  typedef struct packed {
    logic [9:0]  slot;
    logic [31:0] dev;
    logic [63:0] ino;
    logic [63:0] count;
    logic        claimed;
    logic        dropped;
  } resp_t;

  logic [31:0]           tbl_dev   [TABLE_SIZE];
  logic [63:0]           tbl_ino   [TABLE_SIZE];
  logic [63:0]           tbl_count [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] filled_now;
  resp_t                 pending_responses[$];
  int                    mismatches;
  int                    drops;

  // Key bits of an empty slot are never shown in a response.
  function automatic resp_t slot_contents(int unsigned idx, logic claimed);
    resp_t r;
    r.slot    = 10'(idx);
    r.count   = tbl_count[idx];
    r.dev     = (r.count != '0) ? tbl_dev[idx] : '0;
    r.ino     = (r.count != '0) ? tbl_ino[idx] : '0;
    r.claimed = claimed;
    r.dropped = 1'b0;
    return r;
  endfunction

  function automatic resp_t tally_key(logic [31:0] dev, logic [63:0] ino);
    logic [63:0] h;
    int unsigned idx;
    resp_t       r;
    h = (ino * HASH_PRIME) ^ {32'd0, dev};
    for (int p = 0; p < TABLE_SIZE; p++) begin
      idx = int'((h + 64'(p)) & 64'(TABLE_SIZE - 1));
      if (tbl_count[idx] == '0) begin
        tbl_dev[idx]    = dev;
        tbl_ino[idx]    = ino;
        tbl_count[idx]  = 64'd1;
        filled_now[idx] = 1'b1;
        return slot_contents(idx, 1'b1);
      end
      if (tbl_dev[idx] == dev && tbl_ino[idx] == ino) begin
        if (tbl_count[idx] != '1) begin
          tbl_count[idx] = tbl_count[idx] + 64'd1;
        end
        return slot_contents(idx, 1'b0);
      end
    end
    // Every slot holds another key: the request is discarded.
    drops++;
    r = '0;
    r.dropped = 1'b1;
    return r;
  endfunction

  function automatic int field_mismatch(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    resp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        tbl_count[i] = '0;
      end
      filled_now = '0;
      pending_responses.delete();
      mismatches = 0;
      drops = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_responses.size() == 0) begin
          $error("response for slot %0d with no request outstanding", out_slot_i);
          mismatches++;
        end else begin
          want = pending_responses.pop_front();
          mismatches += field_mismatch("slot", 64'(want.slot), 64'(out_slot_i));
          mismatches += field_mismatch("entry_dev", 64'(want.dev), 64'(out_entry_dev_i));
          mismatches += field_mismatch("entry_ino", want.ino, out_entry_ino_i);
          mismatches += field_mismatch("entry_count", want.count, out_entry_count_i);
          mismatches += field_mismatch("newly_claimed", 64'(want.claimed),
                                       64'(out_newly_claimed_i));
          mismatches += field_mismatch("dropped", 64'(want.dropped), 64'(out_dropped_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_kind_i == kch_tb_pkg::KIND_READ) begin
          pending_responses.push_back(
            slot_contents(int'(in_slot_index_i) & (TABLE_SIZE - 1), 1'b0));
        end else begin
          pending_responses.push_back(tally_key(in_dev_i, in_ino_i));
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= pending_responses.size();
    drop_count_o     <= drops;
    filled_o         <= filled_now;
  end

endmodule

@@ test/tb_top.sv @@
// Stimulus and verdict of the key count hash table testbench.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_LOG2   = 10;
  localparam int unsigned TABLE_SIZE   = 2 ** TABLE_LOG2;
  localparam int          RANDOM_ITEMS = 950;
  localparam int          FULL_TAIL    = 60;
  localparam int          DRAIN_CYCLES = TABLE_SIZE + 16;
  localparam int          QUIET_LIMIT  = 4 * (TABLE_SIZE + 32);

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_kind_i       = kch_tb_pkg::KIND_TALLY;
  logic [31:0] in_dev_i        = '0;
  logic [63:0] in_ino_i        = '0;
  logic [9:0]  in_slot_index_i = '0;
  logic        out_ready_i     = 1'b0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic [9:0]  out_slot_o;
  logic [31:0] out_entry_dev_o;
  logic [63:0] out_entry_ino_o;
  logic [63:0] out_entry_count_o;
  logic        out_newly_claimed_o;
  logic        out_dropped_o;

  int                    mismatches;
  int                    pending;
  int                    drops;
  logic [TABLE_SIZE-1:0] filled;

  int          idle_pct    = 0;
  int          stall_left  = 0;
  int          tally_count = 0;
  int          read_count  = 0;
  logic [31:0] sent_dev[$];
  logic [63:0] sent_ino[$];

  always #5 clk_i = ~clk_i;

  key_count_hash_table #(
    .TABLE_LOG2(TABLE_LOG2)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .in_kind_i          (in_kind_i),
    .in_dev_i           (in_dev_i),
    .in_ino_i           (in_ino_i),
    .in_slot_index_i    (in_slot_index_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_slot_o         (out_slot_o),
    .out_entry_dev_o    (out_entry_dev_o),
    .out_entry_ino_o    (out_entry_ino_o),
    .out_entry_count_o  (out_entry_count_o),
    .out_newly_claimed_o(out_newly_claimed_o),
    .out_dropped_o      (out_dropped_o)
  );

  count_table_checker #(
    .TABLE_LOG2(TABLE_LOG2)
  ) u_table_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .in_kind_i          (in_kind_i),
    .in_dev_i           (in_dev_i),
    .in_ino_i           (in_ino_i),
    .in_slot_index_i    (in_slot_index_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_slot_i         (out_slot_o),
    .out_entry_dev_i    (out_entry_dev_o),
    .out_entry_ino_i    (out_entry_ino_o),
    .out_entry_count_i  (out_entry_count_o),
    .out_newly_claimed_i(out_newly_claimed_o),
    .out_dropped_i      (out_dropped_o),
    .mismatch_count_o   (mismatches),
    .pending_count_o    (pending),
    .drop_count_o       (drops),
    .filled_o           (filled)
  );

  // Response stalls come in bursts.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left  <= $urandom_range(0, 8);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_request(kch_tb_pkg::req_kind_e kind, logic [31:0] dev,
                              logic [63:0] ino, logic [9:0] index);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_kind_i       <= kind;
    in_dev_i        <= dev;
    in_ino_i        <= ino;
    in_slot_index_i <= index;
    if (kind == kch_tb_pkg::KIND_READ) begin
      read_count++;
    end else begin
      tally_count++;
    end
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  initial begin : stimulus
    logic [31:0] dev;
    logic [63:0] ino;
    logic [9:0]  index;
    int          pick;
    int          k;
    int          mode_pct;
    int          n_rand;
    int          full_tail;
    bit          table_full;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Keys below mostly hash to slot 0 or 1023, so they collide, probe and wrap.
    send_request(kch_tb_pkg::KIND_TALLY, 32'h0, 64'h0, 10'h3FF);
    send_request(kch_tb_pkg::KIND_TALLY, 32'h0, 64'h0, 10'h000);
    send_request(kch_tb_pkg::KIND_TALLY, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'h000);
    send_request(kch_tb_pkg::KIND_TALLY, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'h2AA);
    send_request(kch_tb_pkg::KIND_TALLY, 32'h0000_0400, 64'h0, 10'h155);
    send_request(kch_tb_pkg::KIND_TALLY, 32'h8000_0000, 64'h0, 10'h3FF);
    send_request(kch_tb_pkg::KIND_TALLY, 32'h0, 64'h8000_0000_0000_0000, 10'h000);
    send_request(kch_tb_pkg::KIND_TALLY, 32'h0000_0400, 64'h0, 10'h000);
    send_request(kch_tb_pkg::KIND_TALLY, 32'h0000_03FF, 64'h0, 10'h000);
    send_request(kch_tb_pkg::KIND_TALLY, 32'h0000_07FF, 64'h0, 10'h000);
    send_request(kch_tb_pkg::KIND_TALLY, 32'h0000_07FF, 64'h0, 10'h000);
    send_request(kch_tb_pkg::KIND_TALLY, 32'h0, 64'h0000_0000_0000_0400, 10'h000);
    send_request(kch_tb_pkg::KIND_READ, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'h000);
    send_request(kch_tb_pkg::KIND_READ, 32'h0, 64'h0, 10'h3FF);
    send_request(kch_tb_pkg::KIND_READ, 32'h0, 64'h0, 10'h004);
    send_request(kch_tb_pkg::KIND_READ, 32'h0, 64'h0, 10'h001);
    send_request(kch_tb_pkg::KIND_READ, 32'h0, 64'h0, 10'h003);
    send_request(kch_tb_pkg::KIND_READ, 32'h0, 64'h0, 10'h005);

    // Mostly new keys until the table is full, then drops, long probes and reads.
    n_rand    = 0;
    full_tail = 0;
    mode_pct  = 0;
    while (n_rand < RANDOM_ITEMS || full_tail < FULL_TAIL) begin
      if (n_rand % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: mode_pct = 0;
          1: mode_pct = 25;
          default: mode_pct = 60;
        endcase
      end
      idle_pct <= (full_tail >= FULL_TAIL / 2) ? 0 : mode_pct;
      table_full = &filled;
      if (table_full) begin
        full_tail++;
      end
      dev   = $urandom;
      ino   = {$urandom, $urandom};
      index = 10'($urandom);
      pick  = $urandom_range(0, 99);
      if (filled != '0 && pick < (table_full ? 30 : 6)) begin
        // Only slots that hold a key are read.
        k = $urandom_range(0, TABLE_SIZE - 1);
        while (!filled[k]) begin
          k = (k + 1) % TABLE_SIZE;
        end
        send_request(kch_tb_pkg::KIND_READ, dev, ino, 10'(k));
      end else begin
        if (sent_dev.size() != 0 && pick < 40) begin
          k = $urandom_range(0, sent_dev.size() - 1);
          if (pick < (table_full ? 60 : 16)) begin
            dev = sent_dev[k];
            ino = sent_ino[k];
          end else if (pick % 2 == 0) begin
            dev = {dev[31:TABLE_LOG2], sent_dev[k][TABLE_LOG2-1:0]};
            ino = sent_ino[k];
          end else begin
            dev = sent_dev[k];
            ino = {ino[63:TABLE_LOG2], sent_ino[k][TABLE_LOG2-1:0]};
          end
        end
        sent_dev.push_back(dev);
        sent_ino.push_back(ino);
        send_request(kch_tb_pkg::KIND_TALLY, dev, ino, index);
      end
      n_rand++;
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d tallies and %0d slot reads; %0d of %0d slots filled.",
             tally_count, read_count, $countones(filled), TABLE_SIZE);
    $display("%0d tallies were dropped on a full table; %0d mismatches.", drops, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: nothing accepted for %0d cycles, %0d responses outstanding.",
             QUIET_LIMIT, pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ key_count_hash_table.f @@
hw/rtl/kch_pkg.sv
hw/rtl/kch_hash.sv
hw/rtl/kch_ram.sv
hw/rtl/key_count_hash_table.sv
test/count_table_checker.sv
test/tb_top.sv
